>>> hdl/cdc_pkg.sv
// Shared types and constants for the content-defined chunker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cdc_pkg;

   // Bytes that make up the value of one position.
   localparam int WINDOW_BYTES = 8;
   localparam int WINDOW_BITS  = 8 * WINDOW_BYTES;

   // Saturation value of the chunk fill counter.
   localparam logic [31:0] FILL_MAX   = 32'hFFFF_FFFF;
   localparam logic [31:0] WINDOW_LEN = 32'(WINDOW_BYTES);

   // Depth of the result queue between classifier and emitter.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Configuration register widths, reset values and indexes.
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [15:0] WINDOW_SIZE_RESET = 16'd2383;
   localparam logic [16:0] MAX_CHUNK_RESET   = 17'd65536;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SIZE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_CHUNK   = 8'd1;

   // One queue entry holds everything a single byte closed. When both a cut
   // and the stream end occur, len is the cut length and the end length is
   // the window size in bytes.
   typedef struct packed {
      logic        has_cut;
      logic        has_end;
      logic [31:0] len;
   } cdc_entry_type;

endpackage

>>> hdl/cdc_front.sv
// Classifier of the chunker: configuration registers, rolling window, extreme
// tracking and cut decision. Pushes one queue entry per byte that closes chunks.
// Depends on cdc_pkg.
`timescale 1ns / 1ps

module cdc_front
   import cdc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_accept,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_end_of_stream,
   output logic                      push,
   output cdc_entry_type             push_entry
);

   logic [15:0]            window_size_ff, window_size_in;
   logic [16:0]            max_chunk_ff, max_chunk_in;
   logic [WINDOW_BITS-1:0] byte_window_ff, byte_window_in;
   logic [WINDOW_BITS-1:0] extreme_value_ff, extreme_value_in;
   logic [31:0]            extreme_offset_ff, extreme_offset_in;
   logic [31:0]            chunk_fill_ff, chunk_fill_in;

   logic [WINDOW_BITS+7:0] shifted;
   logic [WINDOW_BITS-1:0] window_next;
   logic [31:0]            fill_next;
   logic [31:0]            pos;
   logic [32:0]            cut_offset;
   logic                   cut;

   always_comb begin
      window_size_in = window_size_ff;
      max_chunk_in   = max_chunk_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE: window_size_in = csr_wdata[15:0];
            CSR_MAX_CHUNK:   max_chunk_in   = csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      shifted     = {byte_window_ff, req_data_byte};
      window_next = shifted[WINDOW_BITS-1:0];
      fill_next   = (chunk_fill_ff != FILL_MAX) ? chunk_fill_ff + 32'd1 : chunk_fill_ff;
      pos         = fill_next - WINDOW_LEN;
      cut_offset  = {1'b0, extreme_offset_ff} + {17'd0, window_size_ff};

      byte_window_in    = byte_window_ff;
      extreme_value_in  = extreme_value_ff;
      extreme_offset_in = extreme_offset_ff;
      chunk_fill_in     = chunk_fill_ff;
      cut               = 1'b0;
      push              = 1'b0;
      push_entry        = '0;

      if (req_accept) begin
         byte_window_in = window_next;
         chunk_fill_in  = fill_next;
         if (fill_next == WINDOW_LEN) begin
            extreme_value_in  = window_next;
            extreme_offset_in = '0;
         end else if (fill_next > WINDOW_LEN) begin
            if (window_next <= extreme_value_ff) begin
               extreme_value_in  = window_next;
               extreme_offset_in = pos;
            end else if (({1'b0, pos} == cut_offset) || (pos == {15'd0, max_chunk_ff})) begin
               // Cut before this position, by content or by the size limit;
               // the new chunk already holds the window bytes.
               cut               = 1'b1;
               chunk_fill_in     = WINDOW_LEN;
               extreme_value_in  = window_next;
               extreme_offset_in = '0;
            end
         end

         push_entry.has_cut = cut;
         push_entry.has_end = req_end_of_stream;
         push_entry.len     = cut ? pos : chunk_fill_in;
         push               = cut || req_end_of_stream;

         if (req_end_of_stream) begin
            byte_window_in    = '0;
            extreme_value_in  = '0;
            extreme_offset_in = '0;
            chunk_fill_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff    <= WINDOW_SIZE_RESET;
         max_chunk_ff      <= MAX_CHUNK_RESET;
         byte_window_ff    <= '0;
         extreme_value_ff  <= '0;
         extreme_offset_ff <= '0;
         chunk_fill_ff     <= '0;
      end else begin
         window_size_ff    <= window_size_in;
         max_chunk_ff      <= max_chunk_in;
         byte_window_ff    <= byte_window_in;
         extreme_value_ff  <= extreme_value_in;
         extreme_offset_ff <= extreme_offset_in;
         chunk_fill_ff     <= chunk_fill_in;
      end
   end

endmodule

>>> hdl/cdc_queue.sv
// Short FIFO of closed-chunk entries between classifier and emitter.
// Depends on cdc_pkg.
`timescale 1ns / 1ps

module cdc_queue
   import cdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cdc_entry_type push_entry,
   input  logic          pop,
   output cdc_entry_type head,
   output logic          empty,
   output logic          full
);

   cdc_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/cdc_back.sv
// Emitter of the chunker: turns queue entries into one or two result items
// and holds them in the output register. Depends on cdc_pkg.
`timescale 1ns / 1ps

module cdc_back
   import cdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cdc_entry_type head,
   input  logic          empty,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [31:0]   rsp_chunk_length,
   output logic          rsp_closed_by_end,
   output logic          rsp_last_result
);

   logic        valid_ff, valid_in;
   logic        half_ff, half_in;
   logic        load;
   logic [31:0] length_ff, length_in;
   logic        by_end_ff, by_end_in;
   logic        last_ff, last_in;

   assign rsp_valid         = valid_ff;
   assign rsp_chunk_length  = length_ff;
   assign rsp_closed_by_end = by_end_ff;
   assign rsp_last_result   = last_ff;

   always_comb begin
      load      = !valid_ff || !rsp_stall;
      valid_in  = valid_ff;
      half_in   = half_ff;
      length_in = length_ff;
      by_end_in = by_end_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            if (half_ff) begin
               // Second item of a cut that came with the stream end.
               length_in = WINDOW_LEN;
               by_end_in = 1'b1;
               last_in   = 1'b1;
               half_in   = 1'b0;
               pop       = 1'b1;
            end else if (head.has_cut) begin
               length_in = head.len;
               by_end_in = 1'b0;
               last_in   = !head.has_end;
               half_in   = head.has_end;
               pop       = !head.has_end;
            end else begin
               length_in = head.len;
               by_end_in = 1'b1;
               last_in   = 1'b1;
               pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      length_ff <= length_in;
      by_end_ff <= by_end_in;
      last_ff   <= last_in;
   end

endmodule

>>> hdl/content_defined_chunker_unit.sv
// Top level of the content-defined chunker; instantiates cdc_front, cdc_queue
// and cdc_back. Depends on cdc_pkg.
`timescale 1ns / 1ps

// The chunker takes one byte per clock cycle on the req_ channel and reports
// the length of every chunk it closes on the rsp_ channel. A chunk border is
// placed in front of a position that lies window_size bytes past the running
// minimum of the 8-byte big-endian values, or at the chunk size limit, and the
// rest of the stream is reported when a byte marked end_of_stream arrives. The
// classifier decides everything for a byte in the cycle it is accepted, so the
// input sustains one item per cycle while req_stall is low; that cycle is
// bounded by the 64-bit window compare. A byte that closes a chunk and also
// ends the stream produces two result items. A four-entry queue between the
// classifier and the output register absorbs such bursts and short output
// stalls; req_stall rises only while that queue is full.
// The configuration port is always ready; index 0 is window_size, index 1 is
// the chunk size limit, and writes to other indexes are ignored. Registers
// should be written only while no item is in flight.

module content_defined_chunker_unit
   import cdc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_end_of_stream,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               rsp_chunk_length,
   output logic                      rsp_closed_by_end,
   output logic                      rsp_last_result
);

   logic          queue_full;
   logic          queue_empty;
   logic          push;
   logic          pop;
   logic          req_accept;
   cdc_entry_type push_entry;
   cdc_entry_type head;

   assign csr_ready  = 1'b1;
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   cdc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_accept        (req_accept),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .push              (push),
      .push_entry        (push_entry)
   );

   cdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   cdc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .empty             (queue_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chunk_length  (rsp_chunk_length),
      .rsp_closed_by_end (rsp_closed_by_end),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

>>> test/tb.sv
// Self-checking testbench for content_defined_chunker_unit.
// Drives byte streams and register writes, predicts every chunk length and
// compares it with the rsp_ channel; depends on cdc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
   import cdc_pkg::*;

   // Cycles the block may still be busy after its last result has come out:
   // classifier, result queue and output register, with margin.
   localparam int SETTLE_CYCLES = 12;

   // A register index that decodes to nothing; writes to it must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 8'hFF;

   // Kinds of byte content used to build streams.
   typedef enum int {
      CONTENT_RANDOM,
      CONTENT_FLAT,
      CONTENT_RISING,
      CONTENT_FALLING,
      CONTENT_SPLIT
   } content_kind_type;

   // One chunk report as the rsp_ channel should carry it.
   typedef struct {
      logic [31:0] len;
      logic        by_end;
      logic        last;
   } chunk_report_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_data_byte;
   logic                      req_end_of_stream;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [31:0]               rsp_chunk_length;
   logic                      rsp_closed_by_end;
   logic                      rsp_last_result;

   content_defined_chunker_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chunk_length  (rsp_chunk_length),
      .rsp_closed_by_end (rsp_closed_by_end),
      .rsp_last_result   (rsp_last_result)
   );

   // Chunk reports that the block still owes us, oldest first.
   chunk_report_type chunks_due[$];
   int               fail_count = 0;

   // Our own copy of the chunker state and of its two registers.
   logic [WINDOW_BITS-1:0] win_bytes;
   logic [WINDOW_BITS-1:0] low_value;
   logic [31:0]            low_offset;
   logic [31:0]            fill_count;
   logic [15:0]            cut_distance;
   logic [16:0]            cut_limit;

   // Idle rates in percent for each side, and a receiver hold-off counter
   // that the receiver process counts down on its own.
   int req_idle_pct = 17;
   int rsp_idle_pct = 17;
   int hold_cycles  = 0;

   always #4 clock = ~clock;

   // Everything the stream carries is forgotten when a stream ends; the
   // registers survive.
   task automatic forget_stream();
      win_bytes  = '0;
      low_value  = '0;
      low_offset = '0;
      fill_count = '0;
   endtask

   // Registers are masked to their own width; unknown indexes do nothing.
   task automatic apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] data);
      if (idx == CSR_WINDOW_SIZE) begin
         cut_distance = data[15:0];
      end else if (idx == CSR_MAX_CHUNK) begin
         cut_limit = data[16:0];
      end
   endtask

   // Advances the chunker state by one accepted byte and queues every chunk
   // report that the byte closes. A byte can close a chunk by content and
   // then also end the stream, which gives two reports.
   task automatic track_chunk_byte(input logic [7:0] data_byte, input logic eos);
      chunk_report_type closed[$];
      chunk_report_type rep;
      logic [31:0]      pos;
      logic [63:0]      distance_mark;
      win_bytes = {win_bytes[WINDOW_BITS-9:0], data_byte};
      if (fill_count != FILL_MAX) fill_count = fill_count + 1;
      if (fill_count == WINDOW_LEN) begin
         low_value  = win_bytes;
         low_offset = '0;
      end else if (fill_count > WINDOW_LEN) begin
         pos = fill_count - WINDOW_LEN;
         distance_mark = 64'(low_offset) + 64'(cut_distance);
         if (win_bytes <= low_value) begin
            low_value  = win_bytes;
            low_offset = pos;
         end else if (64'(pos) == distance_mark || 64'(pos) == 64'(cut_limit)) begin
            rep.len    = pos;
            rep.by_end = 1'b0;
            rep.last   = 1'b0;
            closed.push_back(rep);
            fill_count = WINDOW_LEN;
            low_value  = win_bytes;
            low_offset = '0;
         end
      end
      if (eos) begin
         rep.len    = fill_count;
         rep.by_end = 1'b1;
         rep.last   = 1'b0;
         closed.push_back(rep);
         forget_stream();
      end
      if (closed.size() > 0) closed[closed.size() - 1].last = 1'b1;
      foreach (closed[i]) chunks_due.push_back(closed[i]);
   endtask

   // Offers one byte, with a random idle gap in front of it. Called and
   // returns at a falling edge; valid stays high when no gap follows.
   task automatic send_byte(input logic [7:0] data_byte, input logic eos);
      if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data_byte;
      req_end_of_stream <= eos;
      do @(posedge clock); while (req_stall);
      track_chunk_byte(data_byte, eos);
      @(negedge clock);
   endtask

   // Stops offering bytes and waits until every owed report has arrived and
   // the block has had time to finish bytes that close nothing.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (chunks_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write. Valid is left high when another write follows at
   // once, so it is never lowered and raised in the same step.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] data,
                                 input bit more_follow);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      @(negedge clock);
      if (!more_follow) csr_valid <= 1'b0;
   endtask

   // Sets both registers while the block is idle. The bits above each
   // register's width carry random junk, which the block must drop.
   task automatic set_chunking(input logic [15:0] distance, input logic [16:0] limit);
      drain_results();
      write_register(CSR_WINDOW_SIZE, ($urandom & 32'hFFFF_0000) | 32'(distance), 1'b1);
      write_register(CSR_MAX_CHUNK, ($urandom & 32'hFFFE_0000) | 32'(limit), 1'b0);
   endtask

   function automatic logic [7:0] pick_byte(input content_kind_type kind, input int k,
                                            input logic [7:0] base);
      if (kind == CONTENT_FLAT) return 8'($urandom_range(3));
      if ((kind == CONTENT_RISING || kind == CONTENT_FALLING) && $urandom_range(7) == 0)
         return 8'($urandom_range(255));
      if (kind == CONTENT_RISING) return base + 8'(k);
      if (kind == CONTENT_FALLING) return base - 8'(k);
      return 8'($urandom_range(255));
   endfunction

   // Sends one stream closed by an end marker. Split streams also carry end
   // markers at random places inside, which breaks them into short pieces.
   task automatic send_stream(input int len);
      content_kind_type kind;
      logic [7:0]       base;
      logic             eos;
      kind = content_kind_type'($urandom_range(4));
      base = 8'($urandom_range(255));
      for (int k = 0; k < len; k++) begin
         eos = (k == len - 1) || (kind == CONTENT_SPLIT && $urandom_range(15) == 0);
         send_byte(pick_byte(kind, k, base), eos);
      end
   endtask

   // Sends whole streams until at least the given number of bytes went out.
   // Most streams are short so that cuts and ends come often.
   task automatic send_streams(input int byte_budget);
      int sent;
      int len;
      sent = 0;
      while (sent < byte_budget) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
         send_stream(len);
         sent += len;
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Compares every accepted result item with the oldest owed report.
   always @(posedge clock) begin
      chunk_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (chunks_due.size() == 0) begin
            $display("%0t ns: result item with nothing expected, expected none, got length %0d",
                     $time, rsp_chunk_length);
            fail_count++;
         end else begin
            want = chunks_due.pop_front();
            check_field("chunk_length", want.len, rsp_chunk_length);
            check_field("closed_by_end", 32'(want.by_end), 32'(rsp_closed_by_end));
            check_field("last_result", 32'(want.last), 32'(rsp_last_result));
         end
      end
   end

   // The receiver stalls at random, or for a whole hold-off when one is
   // requested, and changes its stall only at the falling edge.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Short streams: a single byte at the top of the byte range, and a
   // three-byte stream, both shorter than one window, so each is reported
   // whole at its end.
   task automatic test_short_streams();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   // Cut rules with hand-picked settings. A rising ramp with a distance of
   // one cuts on every byte past the first window, and its last byte both
   // cuts and ends the stream. A write to an unused index must change
   // nothing. Then with no distance cut, a rising ramp is cut by the chunk
   // limit on its last byte, which also ends the stream. A falling run in a
   // fresh stream keeps making new minimums, which are never cut, so that
   // chunk grows past the limit.
   task automatic test_cut_rules();
      set_chunking(16'd1, 17'd0);
      write_register(CSR_UNUSED_INDEX, 32'hFFFF_FFFF, 1'b0);
      for (int k = 1; k <= 10; k++) send_byte(8'(k), k == 10);
      set_chunking(16'd0, 17'd3);
      for (int k = 0; k < 11; k++) send_byte(8'(8'h30 + k), k == 10);
      for (int k = 0; k < 12; k++) send_byte(8'(8'hF0 - 16 * k), k == 11);
   endtask

   // Random streams under a series of settings, from the smallest values
   // through the register limits, including zero distance and zero limit.
   task automatic test_random_settings();
      logic [15:0] distances[8] = '{16'd1, 16'd3, 16'd0, 16'd8, 16'd65535, 16'd0,
                                    16'd5, 16'd0};
      logic [16:0] limits[8]    = '{17'd0, 17'd5, 17'd12, 17'd40, 17'h10000, 17'd0,
                                    17'h1FFFF, 17'd0};
      for (int s = 0; s < 8; s++) begin
         if (s == 7) begin
            set_chunking(16'($urandom_range(1, 24)), 17'($urandom_range(2, 64)));
         end else begin
            set_chunking(distances[s], limits[s]);
         end
         send_streams(170);
      end
   endtask

   // The receiver holds off for a long stretch while the sender offers
   // mostly one-byte streams, so the result queue fills and the block
   // stalls its input. More streams follow, then all reports drain.
   task automatic test_output_backpressure();
      set_chunking(16'd2, 17'd6);
      @(posedge clock);
      hold_cycles = 80;
      @(negedge clock);
      for (int k = 0; k < 40; k++) send_byte(8'($urandom_range(255)), $urandom_range(7) != 0);
      send_streams(20);
      drain_results();
   endtask

   // Back-to-back bytes with the receiver never stalling.
   task automatic test_full_rate();
      set_chunking(16'd4, 17'd20);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_streams(300);
      drain_results();
      req_idle_pct = 17;
      rsp_idle_pct = 17;
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_end_of_stream = 1'b0;
      rsp_stall         = 1'b0;
      cut_distance      = WINDOW_SIZE_RESET;
      cut_limit         = MAX_CHUNK_RESET;
      forget_stream();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_short_streams();
      test_cut_rules();
      test_random_settings();
      test_output_backpressure();
      test_full_rate();

      drain_results();
      if (chunks_due.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Guard against a hang; far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
